// ===== design/assert_macros.svh =====
// Assertion macros shared by the optical flow RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on clk_i, disabled in reset.
`define LKOF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, clocked on clk_i, disabled in reset.
`define LKOF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LKOF_ASSERT_IMP(lbl, ante, cons)
`define LKOF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/lkof_pkg.sv =====
// Shared types and constants of the optical flow block.
`default_nettype none
package lkof_pkg;

  localparam logic [1:0] CFG_FRAME_COLS = 2'd0;
  localparam logic [1:0] CFG_FRAME_ROWS = 2'd1;
  localparam logic [1:0] CFG_FLOW_SCALE = 2'd2;

  typedef struct packed {
    logic signed [8:0] gx;
    logic signed [8:0] gy;
    logic signed [8:0] gt;
  } lkof_grad_t;

  typedef struct packed {
    logic signed [31:0] sxx;
    logic signed [31:0] sxy;
    logic signed [31:0] syy;
    logic signed [31:0] stx;
    logic signed [31:0] sty;
  } lkof_sums_t;

  typedef struct packed {
    logic               singular;
    logic signed [31:0] flow_y;
    logic signed [31:0] flow_x;
  } lkof_result_t;

endpackage
`default_nettype wire

// ===== design/optical_flow_image_interpolation.sv =====
// Top level of the streaming Lucas-Kanade optical flow block.
// Usage:
//   s_axis: one pixel pair per transaction (reference and estimate, raster order).
//   m_axis: one flow result per frame. The user must write frame_cols, frame_rows
//   and flow_scale on cfg only while the block is idle; the block does not check it.
// Timing:
//   A pixel is taken in ST_IDLE, which reads the line stores (two estimate
//   reads and one reference read from synchronous memories); ST_ACC then
//   writes back, updates the window and accumulates the five sums, and no
//   new pixel is taken until it is done. After the last pixel of a frame the
//   solver runs six 33x33 products, two scaling products per flow, and an
//   80-step restoring divider per flow, all on one shared multiplier/subtractor.
// Reset:
//   Sums, counters, line store valid bits clear; size 5x5, scale 100.
// Stall:
//   The result waits in an output register; pixels of the next frame are
//   still taken. Only a second frame end waits until m_axis drains.
`default_nettype none
`include "assert_macros.svh"
module optical_flow_image_interpolation import lkof_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [15:0] s_axis_tdata_i,   // ref_pixel[7:0], est_pixel[15:8]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // flow_x[31:0], flow_y[63:32], singular[64]
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CSW = CW + 1;
  localparam int RSW = RW + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ACC   = 3'b010,
    ST_SOLVE = 3'b100
  } top_state_e;

  top_state_e   state_q;
  logic [6:0]   frame_cols_q, frame_rows_q;
  logic [15:0]  flow_scale_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [7:0]   ref_px_q, est_px_q;
  lkof_sums_t   sums_q;
  logic         m_valid_q;
  lkof_result_t out_q;

  lkof_grad_t   grad;
  logic         solve_done;
  lkof_result_t solve_res;
  logic [CSW-1:0] cols_eff;
  logic [RSW-1:0] rows_eff;
  logic         last_col, last_row, interior, accept, out_load;
  logic signed [17:0] pxx, pxy, pyy, ptx, pty;

  // Hold config in range: sizes clamp to [3, MAX].
  assign cols_eff = (frame_cols_q < 7'd3) ? CSW'(3) :
                    ((32'(frame_cols_q) > MAX_COLS) ? CSW'(MAX_COLS) : CSW'(frame_cols_q));
  assign rows_eff = (frame_rows_q < 7'd3) ? RSW'(3) :
                    ((32'(frame_rows_q) > MAX_ROWS) ? RSW'(MAX_ROWS) : RSW'(frame_rows_q));
  assign last_col = (CSW'(col_q) + CSW'(1)) >= cols_eff;
  assign last_row = (RSW'(row_q) + RSW'(1)) >= rows_eff;
  assign interior = (row_q >= RW'(2)) && (col_q >= CW'(2));

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  lkof_linebuf #(.MAX_COLS(MAX_COLS)) u_linebuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .wr_en_i  (state_q == ST_ACC),
    .col_i    (col_q),
    .parity_i (row_q[0]),
    .est_i    (est_px_q),
    .ref_i    (ref_px_q),
    .grad_o   (grad)
  );

  lkof_solver u_solver (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  ((state_q == ST_ACC) && last_col && last_row),
    .sums_i   (sums_q),
    .scale_i  (flow_scale_q),
    .done_o   (solve_done),
    .result_o (solve_res)
  );

  assign pxx = grad.gx * grad.gx;
  assign pxy = grad.gx * grad.gy;
  assign pyy = grad.gy * grad.gy;
  assign ptx = grad.gt * grad.gx;
  assign pty = grad.gt * grad.gy;

  // Move the solved flow out once the output register is free.
  assign out_load = (state_q == ST_SOLVE) && solve_done && !m_valid_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ref_px_q <= s_axis_tdata_i[7:0];
      est_px_q <= s_axis_tdata_i[15:8];
    end
    if (out_load) out_q <= solve_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cols_q <= 7'd5;
      frame_rows_q <= 7'd5;
      flow_scale_q <= 16'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRAME_COLS: frame_cols_q <= cfg_data_i[6:0];
        CFG_FRAME_ROWS: frame_rows_q <= cfg_data_i[6:0];
        CFG_FLOW_SCALE: flow_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      sums_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (interior) begin
            sums_q.sxx <= sums_q.sxx + 32'(pxx);
            sums_q.sxy <= sums_q.sxy + 32'(pxy);
            sums_q.syy <= sums_q.syy + 32'(pyy);
            sums_q.stx <= sums_q.stx + 32'(ptx);
            sums_q.sty <= sums_q.sty + 32'(pty);
          end
          // Advance the raster position; wrap at the row and frame end.
          if (!last_col) begin
            col_q   <= col_q + CW'(1);
            state_q <= ST_IDLE;
          end else begin
            col_q <= '0;
            if (!last_row) begin
              row_q   <= row_q + RW'(1);
              state_q <= ST_IDLE;
            end else begin
              row_q   <= '0;
              state_q <= ST_SOLVE;
            end
          end
        end
        ST_SOLVE: begin
          if (out_load) begin
            m_valid_q <= 1'b1;
            sums_q    <= '0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.singular, out_q.flow_y, out_q.flow_x};

  `LKOF_ASSERT_NEXT(a_accept_to_acc, accept, state_q == ST_ACC)
  `LKOF_ASSERT_IMP(a_singular_zero, m_valid_q && out_q.singular, out_q.flow_x == '0 && out_q.flow_y == '0)
  `LKOF_ASSERT_NEXT(a_sums_clear, out_load, sums_q.sxx == '0 && sums_q.sty == '0 && m_valid_q)

endmodule
`default_nettype wire

// ===== design/lkof_linebuf.sv =====
// Line stores for estimate and reference rows plus the gradient window.
`default_nettype none
module lkof_linebuf import lkof_pkg::*; #(
  parameter int MAX_COLS = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          rd_en_i,
  input  wire                          wr_en_i,
  input  wire  [$clog2(MAX_COLS)-1:0]  col_i,
  input  wire                          parity_i,
  input  wire  [7:0]                   est_i,
  input  wire  [7:0]                   ref_i,
  output lkof_grad_t                   grad_o
);

  localparam int EAW = $clog2(2 * MAX_COLS);

  logic [7:0] est_mem [2*MAX_COLS];
  logic [7:0] ref_mem [MAX_COLS];
  logic [2*MAX_COLS-1:0] est_vld_q;
  logic [MAX_COLS-1:0]   ref_vld_q;

  logic [EAW-1:0] cur_addr, prev_addr;
  logic [7:0] prev_rd_q, cur_rd_q, ref_rd_q;
  logic [7:0] p1_q, p2_q, above_q, refab_q, last_ep_q;

  assign cur_addr  = parity_i ? (EAW'(MAX_COLS) + EAW'(col_i)) : EAW'(col_i);
  assign prev_addr = parity_i ? EAW'(col_i) : (EAW'(MAX_COLS) + EAW'(col_i));

  // Read ports: never-written entries read as zero.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      prev_rd_q <= est_vld_q[prev_addr] ? est_mem[prev_addr] : 8'd0;
      cur_rd_q  <= est_vld_q[cur_addr] ? est_mem[cur_addr] : 8'd0;
      ref_rd_q  <= ref_vld_q[col_i] ? ref_mem[col_i] : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      est_mem[cur_addr] <= est_i;
      ref_mem[col_i]    <= ref_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_vld_q <= '0;
      ref_vld_q <= '0;
      p1_q      <= '0;
      p2_q      <= '0;
      above_q   <= '0;
      refab_q   <= '0;
      last_ep_q <= '0;
    end else if (wr_en_i) begin
      est_vld_q[cur_addr] <= 1'b1;
      ref_vld_q[col_i]    <= 1'b1;
      p2_q      <= p1_q;
      p1_q      <= prev_rd_q;
      above_q   <= cur_rd_q;
      refab_q   <= ref_rd_q;
      last_ep_q <= est_i;
    end
  end

  // Center is one row up and one column left of the arriving pixel.
  assign grad_o.gx = $signed({1'b0, p2_q}) - $signed({1'b0, prev_rd_q});
  assign grad_o.gy = $signed({1'b0, above_q}) - $signed({1'b0, last_ep_q});
  assign grad_o.gt = $signed({1'b0, refab_q}) - $signed({1'b0, p1_q});

endmodule
`default_nettype wire

// ===== design/lkof_solver.sv =====
// Frame-end solver: shared multiplier and bit-serial divider for the flow.
`default_nettype none
module lkof_solver import lkof_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  input  lkof_sums_t   sums_i,
  input  wire  [15:0]  scale_i,
  output logic         done_o,
  output lkof_result_t result_o
);

  localparam int DIV_STEPS = 80;

  typedef enum logic [7:0] {
    SV_IDLE  = 8'b0000_0001,
    SV_MUL   = 8'b0000_0010,
    SV_DIFF  = 8'b0000_0100,
    SV_SCALE = 8'b0000_1000,
    SV_LOAD  = 8'b0001_0000,
    SV_DIV   = 8'b0010_0000,
    SV_SAT   = 8'b0100_0000,
    SV_DONE  = 8'b1000_0000
  } sv_state_e;

  sv_state_e state_q;
  logic [2:0]         mcnt_q;
  logic signed [63:0] prod_q [6];
  logic [63:0] dmag_q, nmag_q [2];
  logic        dneg_q, nneg_q [2];
  logic        sel_q, scnt_q;
  logic [47:0] lo_q, hi_q;
  logic [79:0] dq_q;
  logic [64:0] rem_q;
  logic [6:0]  dcnt_q;
  lkof_result_t res_q;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;
  logic [63:0] nm;
  logic [64:0] d_det, d_x, d_y, rem_sh;
  logic        ge, big;
  logic [31:0] ql, flow;

  assign nm = nmag_q[sel_q];

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_q == SV_SCALE) begin
      op_a = {1'b0, (scnt_q ? nm[63:32] : nm[31:0])};
      op_b = {17'd0, scale_i};
    end else begin
      case (mcnt_q)
        3'd0: begin op_a = 33'(sums_i.sxx); op_b = 33'(sums_i.syy); end
        3'd1: begin op_a = 33'(sums_i.sxy); op_b = 33'(sums_i.sxy); end
        3'd2: begin op_a = 33'(sums_i.stx); op_b = 33'(sums_i.syy); end
        3'd3: begin op_a = 33'(sums_i.sty); op_b = 33'(sums_i.sxy); end
        3'd4: begin op_a = 33'(sums_i.sty); op_b = 33'(sums_i.sxx); end
        3'd5: begin op_a = 33'(sums_i.stx); op_b = 33'(sums_i.sxy); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  assign prod = op_a * op_b;

  assign d_det = 65'($signed(prod_q[0])) - 65'($signed(prod_q[1]));
  assign d_x   = 65'($signed(prod_q[2])) - 65'($signed(prod_q[3]));
  assign d_y   = 65'($signed(prod_q[4])) - 65'($signed(prod_q[5]));

  assign rem_sh = {rem_q[63:0], dq_q[79]};
  assign ge     = rem_sh >= {1'b0, dmag_q};

  // Truncated quotient, saturated to signed 32 bits.
  assign big = |dq_q[79:32];
  assign ql  = dq_q[31:0];
  always_comb begin
    if (nneg_q[sel_q] != dneg_q) begin
      flow = (big || ql > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - ql);
    end else begin
      flow = (big || ql[31]) ? 32'h7FFF_FFFF : ql;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SV_MUL: prod_q[mcnt_q] <= prod[63:0];
      SV_DIFF: begin
        dneg_q    <= d_det[64];
        dmag_q    <= d_det[64] ? 64'(-d_det) : d_det[63:0];
        nneg_q[0] <= d_x[64];
        nmag_q[0] <= d_x[64] ? 64'(-d_x) : d_x[63:0];
        nneg_q[1] <= d_y[64];
        nmag_q[1] <= d_y[64] ? 64'(-d_y) : d_y[63:0];
      end
      SV_SCALE: begin
        if (scnt_q) hi_q <= prod[47:0];
        else lo_q <= prod[47:0];
      end
      SV_LOAD: begin
        dq_q  <= 80'(lo_q) + {hi_q, 32'd0};
        rem_q <= '0;
      end
      SV_DIV: begin
        rem_q <= ge ? (rem_sh - {1'b0, dmag_q}) : rem_sh;
        dq_q  <= {dq_q[78:0], ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SV_IDLE;
      mcnt_q  <= '0;
      sel_q   <= 1'b0;
      scnt_q  <= 1'b0;
      dcnt_q  <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        SV_IDLE, SV_DONE: begin
          if (start_i) begin
            state_q <= SV_MUL;
            mcnt_q  <= '0;
          end
        end
        SV_MUL: begin
          mcnt_q <= mcnt_q + 3'd1;
          if (mcnt_q == 3'd5) state_q <= SV_DIFF;
        end
        SV_DIFF: begin
          if (d_det == '0) begin
            res_q   <= '{singular: 1'b1, flow_y: '0, flow_x: '0};
            state_q <= SV_DONE;
          end else begin
            res_q.singular <= 1'b0;
            sel_q   <= 1'b0;
            scnt_q  <= 1'b0;
            state_q <= SV_SCALE;
          end
        end
        SV_SCALE: begin
          scnt_q <= ~scnt_q;
          if (scnt_q) state_q <= SV_LOAD;
        end
        SV_LOAD: begin
          dcnt_q  <= '0;
          state_q <= SV_DIV;
        end
        SV_DIV: begin
          dcnt_q <= dcnt_q + 7'd1;
          if (dcnt_q == 7'(DIV_STEPS - 1)) state_q <= SV_SAT;
        end
        SV_SAT: begin
          if (sel_q) begin
            res_q.flow_y <= flow;
            state_q      <= SV_DONE;
          end else begin
            res_q.flow_x <= flow;
            sel_q        <= 1'b1;
            scnt_q       <= 1'b0;
            state_q      <= SV_SCALE;
          end
        end
        default: state_q <= SV_IDLE;
      endcase
    end
  end

  assign done_o   = (state_q == SV_DONE);
  assign result_o = res_q;

endmodule
`default_nettype wire

// ===== bench/optical_flow_image_interpolation_tb.sv =====
// Self-checking testbench for the streaming Lucas-Kanade optical flow block.
`default_nettype none
module optical_flow_image_interpolation_tb;
  import lkof_pkg::*;

  localparam int MAX_COLS    = 64;
  localparam int MAX_ROWS    = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 300;   // margin for the solver to finish after a frame end
  localparam int ITEM_TARGET = 2000;
  localparam int QUIET_TAIL  = 300;

  typedef struct {
    bit [7:0]     rp;
    bit [7:0]     ep;
    bit           typed;
    lkof_result_t res;
  } pixel_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic [15:0] s_data;
  logic        m_ready;
  logic        cfg_valid;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [71:0] m_axis_tdata_o;
  wire         cfg_ready_o;

  optical_flow_image_interpolation #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),          // ref_pixel[7:0], est_pixel[15:8]
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // flow_x[31:0], flow_y[63:32], singular[64]
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Predictor state: line stores, window holds, sums, counters, registers.
  bit [7:0]  est_rows [2*MAX_COLS];
  bit [7:0]  ref_row  [MAX_COLS];
  bit [7:0]  est_held, ref_held;
  bit [31:0] acc_xx, acc_xy, acc_yy, acc_tx, acc_ty;
  int        pos_col, pos_row;
  bit [6:0]  reg_cols, reg_rows;
  bit [15:0] reg_scale;

  lkof_result_t flow_expected[$];
  int  error_count;
  int  results_seen;
  int  singular_seen;
  int  pixels_sent;
  int  frames_sent;
  bit  quiet;
  bit  long_hold;
  longint cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Clamp a size register into the range the block supports.
  function automatic int eff_size(input bit [6:0] v, input int hi);
    if (v < 3) return 3;
    return (v > hi) ? hi : int'(v);
  endfunction

  function automatic logic signed [65:0] cross_diff(input longint a, input longint b,
                                                    input longint c, input longint d);
    logic signed [65:0] p;
    logic signed [65:0] q;
    p = a * b;
    q = c * d;
    return p - q;
  endfunction

  // Scale, divide toward zero and saturate to signed 32 bits.
  function automatic logic [31:0] scaled_quotient(input logic signed [65:0] num,
                                                  input logic signed [65:0] den);
    bit [63:0]  nmag, dmag;
    bit [127:0] q;
    bit         neg;
    nmag = (num < 0) ? 64'(-num) : 64'(num);
    dmag = (den < 0) ? 64'(-den) : 64'(den);
    neg  = (num < 0) != (den < 0);
    q    = ({64'd0, nmag} * {112'd0, reg_scale}) / {64'd0, dmag};
    if (neg) begin
      if (q > 128'h8000_0000) return 32'h8000_0000;
      return 32'(0) - q[31:0];
    end
    if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // Advance the flow predictor by one pixel pair; return 1 at a frame end.
  function automatic bit predict_flow_step(input bit [7:0] rp, input bit [7:0] ep,
                                           output lkof_result_t res);
    int cols, rows, c, r, cur, prv, gx, gy, gt;
    logic signed [65:0] det, nx, ny;
    cols = eff_size(reg_cols, MAX_COLS);
    rows = eff_size(reg_rows, MAX_ROWS);
    c    = pos_col;
    r    = pos_row;
    cur  = (r & 1) * MAX_COLS;
    prv  = ((r + 1) & 1) * MAX_COLS;
    res  = '0;
    if (r >= 2 && c >= 2) begin
      gx = int'(est_rows[prv + c - 2]) - int'(est_rows[prv + c]);
      gy = int'(est_held) - int'(est_rows[cur + c - 1]);
      gt = int'(ref_held) - int'(est_rows[prv + c - 1]);
      acc_xx += gx * gx;
      acc_xy += gx * gy;
      acc_yy += gy * gy;
      acc_tx += gt * gx;
      acc_ty += gt * gy;
    end
    est_held         = est_rows[cur + c];
    ref_held         = ref_row[c];
    est_rows[cur + c] = ep;
    ref_row[c]       = rp;
    if (c + 1 < cols) begin
      pos_col = c + 1;
      return 1'b0;
    end
    pos_col = 0;
    if (r + 1 < rows) begin
      pos_row = r + 1;
      return 1'b0;
    end
    pos_row = 0;
    det = cross_diff($signed(acc_xx), $signed(acc_yy), $signed(acc_xy), $signed(acc_xy));
    nx  = cross_diff($signed(acc_tx), $signed(acc_yy), $signed(acc_ty), $signed(acc_xy));
    ny  = cross_diff($signed(acc_ty), $signed(acc_xx), $signed(acc_tx), $signed(acc_xy));
    if (det == 0) begin
      res.singular = 1'b1;
    end else begin
      res.flow_x = scaled_quotient(nx, det);
      res.flow_y = scaled_quotient(ny, det);
    end
    acc_xx = '0; acc_xy = '0; acc_yy = '0; acc_tx = '0; acc_ty = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s mismatch: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Offer one pixel pair, hold it until taken, then queue the expected flow if it ends a frame.
  task automatic push_pixel(input bit [7:0] rp, input bit [7:0] ep, input bit typed,
                            input lkof_result_t typed_res);
    lkof_result_t res;
    bit           has_res;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {ep, rp};
    do @(posedge clk_i); while (!s_axis_tready_o);
    has_res = predict_flow_step(rp, ep, res);
    if (has_res) begin
      flow_expected.push_back(typed ? typed_res : res);
      frames_sent++;
    end
    pixels_sent++;
  endtask

  // Drain all pending results, let the solver settle, then write one register.
  task automatic write_reg(input logic [1:0] idx, input bit [15:0] val);
    s_valid <= 1'b0;
    while (flow_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FRAME_COLS: reg_cols  = val[6:0];
      CFG_FRAME_ROWS: reg_rows  = val[6:0];
      CFG_FLOW_SCALE: reg_scale = val;
      default: ;
    endcase
  endtask

  // Result side: random stall bursts, one long hold on request.
  initial begin
    m_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        m_ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    lkof_result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = lkof_result_t'(m_axis_tdata_o[64:0]);
      if (flow_expected.size() == 0) begin
        report_mismatch("unexpected result", got.flow_x, 32'd0);
      end else begin
        want = flow_expected.pop_front();
        if (got.flow_x !== want.flow_x) report_mismatch("flow_x", got.flow_x, want.flow_x);
        if (got.flow_y !== want.flow_y) report_mismatch("flow_y", got.flow_y, want.flow_y);
        if (got.singular !== want.singular)
          report_mismatch("singular", 32'(got.singular), 32'(want.singular));
        results_seen++;
        if (got.singular === 1'b1) singular_seen++;
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    pixel_row_t   directed_rows[18];
    lkof_result_t singular_res;
    int           mode, npix, cols, rows, base, dx, dy, shift, ri, ei, pick;
    bit [7:0]     rp, ep;

    s_valid   = 1'b0;
    s_data    = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FRAME_COLS;
    cfg_data  = '0;
    quiet     = 1'b0;
    long_hold = 1'b0;
    error_count = 0; results_seen = 0; singular_seen = 0;
    pixels_sent = 0; frames_sent = 0;
    foreach (est_rows[i]) est_rows[i] = '0;
    foreach (ref_row[i]) ref_row[i] = '0;
    est_held = '0; ref_held = '0;
    acc_xx = '0; acc_xy = '0; acc_yy = '0; acc_tx = '0; acc_ty = '0;
    pos_col = 0; pos_row = 0;
    reg_cols = 7'd5; reg_rows = 7'd5; reg_scale = 16'd100;

    singular_res          = '0;
    singular_res.singular = 1'b1;
    // A flat frame has no gradient, so its determinant is zero; then
    // a checkerboard of extreme values, checked by the predictor.
    directed_rows = '{
      '{8'h00, 8'h00, 1'b0, '0}, '{8'h00, 8'h00, 1'b0, '0}, '{8'h00, 8'h00, 1'b0, '0},
      '{8'h00, 8'h00, 1'b0, '0}, '{8'h00, 8'h00, 1'b0, '0}, '{8'h00, 8'h00, 1'b0, '0},
      '{8'h00, 8'h00, 1'b0, '0}, '{8'h00, 8'h00, 1'b0, '0}, '{8'h00, 8'h00, 1'b1, singular_res},
      '{8'hFF, 8'h00, 1'b0, '0}, '{8'h00, 8'hFF, 1'b0, '0}, '{8'hFF, 8'h00, 1'b0, '0},
      '{8'h00, 8'hFF, 1'b0, '0}, '{8'hFF, 8'h00, 1'b0, '0}, '{8'h00, 8'hFF, 1'b0, '0},
      '{8'hFF, 8'hFF, 1'b0, '0}, '{8'h00, 8'h00, 1'b0, '0}, '{8'hFF, 8'h7F, 1'b0, '0}
    };

    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame for the directed part.
    write_reg(CFG_FRAME_COLS, 16'd3);
    write_reg(CFG_FRAME_ROWS, 16'd3);
    foreach (directed_rows[i])
      push_pixel(directed_rows[i].rp, directed_rows[i].ep, directed_rows[i].typed,
                 directed_rows[i].res);

    // Random phases: each may change some settings, then sends a run of frames.
    for (int phase = 0; pixels_sent < ITEM_TARGET; phase++) begin
      pick = $urandom_range(0, 19);
      if (phase == 0) begin
        write_reg(CFG_FLOW_SCALE, 16'd0);
      end else if (phase == 1) begin
        write_reg(CFG_FLOW_SCALE, 16'hFFFF);
      end else if (phase == 2) begin
        write_reg(CFG_FRAME_COLS, 16'd0);      // clamps up to 3
        write_reg(CFG_FRAME_ROWS, 16'd127);    // clamps down to 64
      end else if (phase == 3) begin
        write_reg(CFG_FRAME_COLS, 16'hFFFF);   // clamps down to 64
        write_reg(CFG_FRAME_ROWS, 16'd2);      // clamps up to 3
      end else if (phase == 5) begin
        // small frames so a second frame end waits behind a stalled receiver
        write_reg(CFG_FRAME_COLS, 16'd4);
        write_reg(CFG_FRAME_ROWS, 16'd4);
      end else if (pick == 0) begin
        write_reg(CFG_FLOW_SCALE, 16'($urandom_range(0, 1) ? 1 : $urandom_range(0, 65535)));
      end else if (pick < 8) begin
        write_reg(CFG_FRAME_COLS, 16'($urandom_range(3, 8)));
        write_reg(CFG_FRAME_ROWS, 16'($urandom_range(3, 8)));
        if ($urandom_range(0, 2) == 0)
          write_reg(CFG_FLOW_SCALE, 16'($urandom_range(1, 65535)));
      end else if (pick == 8) begin
        // cols and rows below their floor, with random upper bits in the data
        write_reg(CFG_FRAME_COLS, 16'({$urandom_range(0, 511), 7'($urandom_range(0, 2))}));
        write_reg(CFG_FRAME_ROWS, 16'({$urandom_range(0, 511), 7'($urandom_range(0, 2))}));
      end
      cols = eff_size(reg_cols, MAX_COLS);
      rows = eff_size(reg_rows, MAX_ROWS);
      // Mostly whole frames; now and then a partial one so the next size
      // change lands mid-frame.
      if (cols * rows > 100) npix = cols * rows;
      else npix = cols * rows * $urandom_range(1, 4);
      if ($urandom_range(0, 5) == 0) npix = $urandom_range(1, npix);
      if (phase == 5) begin
        long_hold = 1'b1;                      // receiver stalls, block fills up
        npix = cols * rows * 6;
      end
      if (pixels_sent + npix > ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;

      mode  = $urandom_range(0, 5);
      base  = $urandom_range(0, 255);
      dx    = $urandom_range(0, 40) - 20;
      dy    = $urandom_range(0, 40) - 20;
      shift = $urandom_range(0, 6) - 3;
      for (int k = 0; k < npix; k++) begin
        case (mode)
          0, 1: begin
            // shifted ramp with noise: well-formed motion
            ei = base + dx * pos_col + dy * pos_row + $urandom_range(0, 6);
            ri = base + dx * (pos_col + shift) + dy * (pos_row - shift) + $urandom_range(0, 6);
            ep = 8'(ei);
            rp = 8'(ri);
          end
          2: begin
            ep = 8'(base);
            rp = 8'(base + shift);
          end
          3: begin
            ep = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            rp = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          end
          default: begin
            ep = 8'($urandom_range(0, 255));
            rp = 8'($urandom_range(0, 255));
          end
        endcase
        push_pixel(rp, ep, 1'b0, '0);
      end
    end

    s_valid <= 1'b0;
    while (flow_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("Covered %0d pixel pairs, %0d frame ends, %0d results (%0d singular)",
             pixels_sent, frames_sent, results_seen, singular_seen);
    $display("Sizes from 3 to 64 incl. clamped values, scales 0..65535, one long output stall");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
